### hdl/unsigned_divider_64_by_32_top_macros.svh
// assertion macros shared by the divider checker
// no dependencies; include by bare file name
`ifndef UNSIGNED_DIVIDER_64_BY_32_TOP_MACROS_SVH
`define UNSIGNED_DIVIDER_64_BY_32_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define UDIV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("udiv assertion failed");

// checked on every clock edge while reset is held
`define UDIV_ASSERT_IN_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) !rst_n |-> prop) \
		else $error("udiv reset assertion failed");

`endif

### hdl/udiv_pkg.sv
// types and constants shared by the 64 by 32 divider modules
// no dependencies
`timescale 1ns / 1ps

package udiv_pkg;

	localparam int unsigned DIVIDEND_W = 64;
	localparam int unsigned DIVISOR_W  = 32;
	localparam int unsigned STEP_W     = $clog2(DIVIDEND_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

	typedef struct packed {
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} req_t;

	typedef struct packed {
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} res_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BUSY = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

### hdl/udiv_ctrl.sv
// divider controller: state machine, step counter, result valid
// depends on udiv_pkg
`timescale 1ns / 1ps

module udiv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            res_valid,
	input  logic            res_ready,
	output udiv_pkg::cmd_t  cmd
);
	import udiv_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	logic              slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BUSY;
				end
			end
			ST_BUSY: begin
				cmd.step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to be free
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/udiv_dpath.sv
// divider datapath: shift registers, trial subtract, result register
// depends on udiv_pkg
`timescale 1ns / 1ps

module udiv_dpath (
	input  logic           clk,
	input  udiv_pkg::cmd_t cmd,
	input  udiv_pkg::req_t req,
	output udiv_pkg::res_t res
);
	import udiv_pkg::*;

	// dividend bits leave at the top, quotient bits enter at the bottom
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	res_t                  res_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W+1:0]  diff;
	logic                  fits;

	assign trial = {rem_q, num_q[DIVIDEND_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = !diff[DIVISOR_W+1];
	assign res   = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (cmd.step) begin
			num_q <= {num_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
		if (cmd.emit) begin
			res_q.quotient  <= num_q;
			res_q.remainder <= rem_q;
		end
	end

endmodule

### hdl/unsigned_divider_64_by_32_top.sv
// Unsigned 64 by 32 restoring divider. A request carries a 64-bit dividend and
// a 32-bit divisor; one result comes back per request with the 64-bit quotient
// (truncated toward zero) and the 32-bit remainder. One quotient bit is
// produced per clock by a single 33-bit trial subtract. The operands load at
// the accepting edge, then come 64 subtract steps, then the answer moves into
// the output register once that register is free. A new request is taken once
// the previous one has reached the output register, even if that result has
// not yet been collected; the controller returns to idle after publishing a
// result and accepts the next request from there.
// A zero divisor is not flagged: the quotient comes back as all ones and the
// remainder as the low 32 bits of the dividend. Both channels are valid/ready;
// reset is asynchronous and active low, and no clearing pass follows it.
// depends on udiv_pkg, udiv_ctrl, udiv_dpath
`timescale 1ns / 1ps

module unsigned_divider_64_by_32_top (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           req_valid,
	output logic           req_ready,
	input  udiv_pkg::req_t req,
	// result channel
	output logic           res_valid,
	input  logic           res_ready,
	output udiv_pkg::res_t res
);
	import udiv_pkg::*;

	// per-cycle commands: load request, run one step, publish result
	cmd_t cmd;

	// sequencing and handshakes
	udiv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd       (cmd)
	);

	// shift-subtract datapath and output register
	udiv_dpath u_dpath (
		.clk (clk),
		.cmd (cmd),
		.req (req),
		.res (res)
	);

endmodule

### hdl/udiv_chk.sv
// port-level checker for the divider, bound to the top level
// depends on udiv_pkg and unsigned_divider_64_by_32_top_macros.svh
`timescale 1ns / 1ps
`include "unsigned_divider_64_by_32_top_macros.svh"

module udiv_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           res_valid,
	input logic           res_ready,
	input udiv_pkg::res_t res
);
	import udiv_pkg::*;

	// a stalled result holds
	`UDIV_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res))
	// busy straight after taking a request
	`UDIV_ASSERT(a_busy_after_req, clk, arst_n, req_valid && req_ready |=> !req_ready)
	// still busy on the last of the 64 steps
	`UDIV_ASSERT(a_busy_all_steps, clk, arst_n, req_valid && req_ready |-> ##64 !req_ready)
	// a new result only appears after a busy cycle
	`UDIV_ASSERT(a_res_from_busy, clk, arst_n, $rose(res_valid) |-> !$past(req_ready))
	// nothing to deliver while in reset
	`UDIV_ASSERT_IN_RST(a_rst_quiet, clk, arst_n, !res_valid)

endmodule

bind unsigned_divider_64_by_32_top udiv_chk u_udiv_chk (.*);

### tb/sv/tb.sv
// self-checking bench for the 64 by 32 restoring divider
// depends on udiv_pkg and unsigned_divider_64_by_32_top
`timescale 1ns / 1ps

module tb;

	localparam int unsigned RANDOM_REQUESTS = 950;
	// one request occupies the divider for a whole division, plus random idle gaps of up to MAX_IDLE each side
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned DRAIN_CYCLES    = 100;
	// long receiver hold-off so the output register and the datapath both fill
	localparam int unsigned HOLD_OFF_AT     = 120;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned MAX_IDLE        = 8;

	// directed requests; answer typed in only where it is obvious
	typedef struct packed {
		logic [udiv_pkg::DIVIDEND_W-1:0] dividend;
		logic [udiv_pkg::DIVISOR_W-1:0]  divisor;
		logic                            typed;
		logic [udiv_pkg::DIVIDEND_W-1:0] quotient;
		logic [udiv_pkg::DIVISOR_W-1:0]  remainder;
	} probe_t;

	localparam int unsigned N_PROBES = 19;
	localparam probe_t PROBES [N_PROBES] = '{
		// smallest dividend, unit divisor
		'{64'h0000_0000_0000_0000, 32'h0000_0001, 1'b1, 64'h0000_0000_0000_0000, 32'h0000_0000},
		// largest dividend, unit divisor
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000},
		// both at their maximum
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'h0000_0001_0000_0001, 32'h0000_0000},
		// zero divisor: all-ones quotient, low half of dividend as remainder
		'{64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000},
		'{64'h1234_5678_9ABC_DEF0, 32'h0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h9ABC_DEF0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
		'{64'h0000_0000_0000_0007, 32'h0000_0002, 1'b1, 64'h0000_0000_0000_0003, 32'h0000_0001},
		// dividend below divisor
		'{64'h0000_0000_0000_0005, 32'h0000_0007, 1'b1, 64'h0000_0000_0000_0000, 32'h0000_0005},
		'{64'h8000_0000_0000_0000, 32'h0000_0002, 1'b1, 64'h4000_0000_0000_0000, 32'h0000_0000},
		'{64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 64'h0000_0001_0000_0000, 32'h0000_0000},
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0002, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0001},
		'{64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 1'b1, 64'h0000_0001_0000_0000, 32'h0000_0000},
		// square of the largest divisor
		'{64'hFFFF_FFFE_0000_0001, 32'hFFFF_FFFF, 1'b1, 64'h0000_0000_FFFF_FFFF, 32'h0000_0000},
		// largest possible remainder
		'{64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 64'h0000_0001_0000_0000, 32'hFFFF_FFFE},
		'{64'hFFFF_FFFE_0000_0000, 32'hFFFF_FFFF, 1'b0, 64'h0, 32'h0},
		'{64'hDEAD_BEEF_CAFE_F00D, 32'h0001_0003, 1'b0, 64'h0, 32'h0},
		'{64'h0000_0000_FFFF_FFFF, 32'h0000_FFFF, 1'b0, 64'h0, 32'h0},
		'{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 64'h0, 32'h0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 64'h0, 32'h0}
	};

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	udiv_pkg::req_t req = '0;
	logic           res_valid;
	logic           res_ready = 1'b0;
	udiv_pkg::res_t res;

	// typed answer travelling alongside the request on the bus
	logic           row_typed = 1'b0;
	udiv_pkg::res_t row_answer = '0;

	udiv_pkg::res_t answers_due [$];
	int unsigned    mismatches = 0;
	int unsigned    cycles = 0;

	unsigned_divider_64_by_32_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	// restoring division, one quotient bit per step from the top dividend bit
	function automatic udiv_pkg::res_t divide_u64_by_u32(input udiv_pkg::req_t r);
		logic [udiv_pkg::DIVIDEND_W-1:0] part;
		logic [udiv_pkg::DIVIDEND_W-1:0] quo;
		logic [udiv_pkg::DIVIDEND_W-1:0] den;
		udiv_pkg::res_t                  a;
		part = '0;
		quo  = '0;
		den  = {{(udiv_pkg::DIVIDEND_W - udiv_pkg::DIVISOR_W){1'b0}}, r.divisor};
		for (int k = udiv_pkg::DIVIDEND_W - 1; k >= 0; k--) begin
			part = {part[udiv_pkg::DIVIDEND_W-2:0], r.dividend[k]};
			quo  = {quo[udiv_pkg::DIVIDEND_W-2:0], 1'b0};
			// a zero divisor always passes, so the whole dividend collects here
			if (part >= den) begin
				part   = part - den;
				quo[0] = 1'b1;
			end
		end
		a.quotient  = quo;
		a.remainder = part[udiv_pkg::DIVISOR_W-1:0];
		return a;
	endfunction

	// idle cycles before the next request or result; every third stretch runs flat out
	function automatic int unsigned idle_draw(input int unsigned n);
		if (((n / 120) % 3) == 2)
			return 0;
		return $urandom_range(0, MAX_IDLE);
	endfunction

	// random request, weighted towards divisors that exercise the corners
	function automatic udiv_pkg::req_t draw_request();
		udiv_pkg::req_t r;
		int unsigned    pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			r.divisor = '0;
		else if (pick < 15)
			r.divisor = $urandom_range(1, 15);
		else if (pick < 25)
			r.divisor = 32'h1 << $urandom_range(0, 31);
		else if (pick < 32)
			r.divisor = 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			r.divisor = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			r.dividend = {32'h0, $urandom} >> $urandom_range(0, 31);
		else if (pick < 15)
			r.dividend = 64'hFFFF_FFFF_FFFF_FFFF;
		else if (pick < 25)
			r.dividend = {$urandom, $urandom} >> $urandom_range(0, 63);
		else
			r.dividend = {$urandom, $urandom};
		return r;
	endfunction

	// present one request at a falling edge and hold it until taken
	task automatic offer(input udiv_pkg::req_t r, input logic typed,
			input udiv_pkg::res_t answer, input int unsigned gap);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid  <= 1'b1;
		req        <= r;
		row_typed  <= typed;
		row_answer <= answer;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// scoreboard: sampled at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		udiv_pkg::res_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				answers_due.push_back(row_typed ? row_answer : divide_u64_by_u32(req));
			if (res_valid && res_ready) begin
				if (answers_due.size() == 0) begin
					$error("result with no request outstanding: quotient %h remainder %h",
						res.quotient, res.remainder);
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					if (res.quotient !== want.quotient) begin
						$error("quotient: expected %h, got %h", want.quotient, res.quotient);
						mismatches++;
					end
					if (res.remainder !== want.remainder) begin
						$error("remainder: expected %h, got %h", want.remainder,
							res.remainder);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL unsigned_divider_64_by_32_top");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int unsigned stall;
		int unsigned collected;
		collected = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = (collected == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : idle_draw(collected);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			collected++;
			@(negedge clk);
		end
	end

	// request side, then drain and verdict
	initial begin
		udiv_pkg::res_t typed_answer;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_PROBES; i++) begin
			typed_answer.quotient  = PROBES[i].quotient;
			typed_answer.remainder = PROBES[i].remainder;
			offer({PROBES[i].dividend, PROBES[i].divisor}, PROBES[i].typed, typed_answer,
				idle_draw(i));
		end

		for (int i = 0; i < RANDOM_REQUESTS; i++)
			offer(draw_request(), 1'b0, '0, idle_draw(i));
		req_valid <= 1'b0;

		// every request answered, then a little slack for stray results
		wait (answers_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("PASS unsigned_divider_64_by_32_top");
		else
			$display("FAIL unsigned_divider_64_by_32_top");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/udiv_pkg.sv
hdl/udiv_ctrl.sv
hdl/udiv_dpath.sv
hdl/unsigned_divider_64_by_32_top.sv
hdl/udiv_chk.sv
tb/sv/tb.sv
